// ===== sv/ihc_pkg.sv =====
`timescale 1ns / 1ps

package ihc_pkg;

  localparam int WordW   = 16;
  localparam int AddrW   = 32;
  localparam int StatusW = 3;
  localparam int CountW  = 4;

  localparam logic [CountW-1:0] LastWord  = 4'd9;
  localparam logic [CountW-1:0] WordHdr   = 4'd0;
  localparam logic [CountW-1:0] WordTtl   = 4'd4;
  localparam logic [CountW-1:0] WordDstHi = 4'd8;

  localparam logic [3:0]       IpVersion  = 4'd4;
  localparam logic [3:0]       MinIhl     = 4'd5;
  localparam logic [AddrW-1:0] Broadcast  = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CsumGood   = 16'hFFFF;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPT  = 3'd0,
    ST_VERSION = 3'd1,
    ST_HDRLEN  = 3'd2,
    ST_TTL     = 3'd3,
    ST_DEST    = 3'd4,
    ST_CSUM    = 3'd5
  } status_t;

  // ones' complement add, end-around carry folded in
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0]   s;
    logic [WordW:0]   f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[WordW-1:0]} + {{WordW{1'b0}}, s[WordW]};
    return f[WordW-1:0];
  endfunction

endpackage

// ===== sv/ipv4_header_checker.sv =====
`timescale 1ns / 1ps
// A verdict is on m_tvalid in the cycle after the tenth header word's beat.
// One header word per cycle, headers back to back, except as the next line says.
// The last word of a header waits only while an earlier verdict is still unread.
// Reset: synchronous, active high; clears the word count, sum, error, the
// pending verdict and local_address.
module ipv4_header_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ihc_pkg::WordW-1:0]  s_tdata,   // [15:0] header_word
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [2:0] status, [7:3] zero
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ihc_pkg::AddrW-1:0]  cfg_data   // [31:0] local_address
);
  import ihc_pkg::*;

  logic [CountW-1:0]  word_count, word_count_next;
  logic [WordW-1:0]   sum_accum, sum_next;
  logic [WordW-1:0]   dest_high, dest_high_next;
  status_t            first_error, err_next;
  logic [AddrW-1:0]   local_address;
  status_t            status;
  logic               out_valid;

  logic               is_last;
  logic               in_beat;
  logic [AddrW-1:0]   dest;

  assign is_last   = (word_count >= LastWord);
  // a non-final word never produces a verdict, so it is always taken
  assign s_tready  = !(is_last && out_valid && !m_tready);
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(8-StatusW){1'b0}}, status};

  assign dest = {dest_high, s_tdata};

  always_comb begin
    sum_next        = oc_add(sum_accum, s_tdata);
    err_next        = first_error;
    dest_high_next  = dest_high;
    word_count_next = word_count + 4'd1;

    if (word_count == WordHdr) begin
      if (s_tdata[15:12] != IpVersion && err_next == ST_ACCEPT) err_next = ST_VERSION;
      if (s_tdata[11:8] < MinIhl && err_next == ST_ACCEPT) err_next = ST_HDRLEN;
    end else if (word_count == WordTtl) begin
      if (s_tdata[15:8] == 8'd0 && err_next == ST_ACCEPT) err_next = ST_TTL;
    end else if (word_count == WordDstHi) begin
      dest_high_next = s_tdata;
    end

    if (is_last) begin
      if (dest != local_address && dest != Broadcast && err_next == ST_ACCEPT)
        err_next = ST_DEST;
      if (sum_next != CsumGood && err_next == ST_ACCEPT) err_next = ST_CSUM;
      word_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      sum_accum     <= '0;
      dest_high     <= '0;
      first_error   <= ST_ACCEPT;
      local_address <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) local_address <= cfg_data;

      // a new verdict may replace one read in the same cycle
      if (in_beat && is_last) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;

      if (in_beat) begin
        word_count <= word_count_next;
        if (is_last) begin
          sum_accum   <= '0;
          dest_high   <= '0;
          first_error <= ST_ACCEPT;
        end else begin
          sum_accum   <= sum_next;
          dest_high   <= dest_high_next;
          first_error <= err_next;
        end
      end
    end
  end

  // verdict payload, loaded on the last word's beat
  always_ff @(posedge clk) begin
    if (in_beat && is_last) status <= err_next;
  end

endmodule

// ===== sv/ihc_checker.sv =====
`timescale 1ns / 1ps
module ihc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [7:0]                m_tdata
);
  import ihc_pkg::*;

  // verdict codes stay within the defined range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[StatusW-1:0] <= ST_CSUM && m_tdata[7:StatusW] == '0))
    else $error("status out of range");

  // a stalled verdict beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("verdict dropped or changed while stalled");

  // a new verdict follows an input beat
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("verdict without an input beat");

  // no pending verdict straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind ipv4_header_checker ihc_checker u_ihc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/ipv4_header_checker_tb.sv =====
`timescale 1ns / 1ps

module ipv4_header_checker_tb;
  import ihc_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 4;
  localparam int IdlePct      = 7;

  // Tracks word position, running sum and first fault; holds the verdicts still owed.
  class verdict_predictor;
    logic [CountW-1:0] word_idx;
    logic [WordW-1:0]  csum;
    logic [WordW-1:0]  dst_hi;
    status_t           first_err;
    logic [AddrW-1:0]  local_addr;
    status_t           pending[$];
    int                errors;

    function new();
      word_idx   = '0;
      csum       = '0;
      dst_hi     = '0;
      first_err  = ST_ACCEPT;
      local_addr = '0;
      errors     = 0;
    endfunction

    static function logic [WordW-1:0] fold_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b);
      logic [WordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      s = {1'b0, s[WordW-1:0]} + {{WordW{1'b0}}, s[WordW]};
      return s[WordW-1:0];
    endfunction

    function void note(status_t code);
      if (first_err == ST_ACCEPT) first_err = code;
    endfunction

    function void take_word(logic [WordW-1:0] w);
      logic [AddrW-1:0] dst;
      csum = fold_add(csum, w);
      case (word_idx)
        WordHdr: begin
          if (w[15:12] != IpVersion) note(ST_VERSION);
          if (w[11:8] < MinIhl) note(ST_HDRLEN);
        end
        WordTtl: begin
          if (w[15:8] == 8'd0) note(ST_TTL);
        end
        WordDstHi: begin
          dst_hi = w;
        end
        default: ;
      endcase
      if (word_idx >= LastWord) begin
        dst = {dst_hi, w};
        if (dst != local_addr && dst != Broadcast) note(ST_DEST);
        if (csum != CsumGood) note(ST_CSUM);
        pending.push_back(first_err);
        word_idx  = '0;
        csum      = '0;
        dst_hi    = '0;
        first_err = ST_ACCEPT;
      end else begin
        word_idx = word_idx + 4'd1;
      end
    endfunction

    function void check_verdict(logic [7:0] beat);
      status_t want;
      if (pending.size() == 0) begin
        $error("status: expected none, got %0d", beat[2:0]);
        errors++;
      end else begin
        want = pending.pop_front();
        if (beat[2:0] !== want) begin
          $error("status: expected %0d, got %0d", want, beat[2:0]);
          errors++;
        end
        if (beat[7:3] !== 5'd0) begin
          $error("m_tdata[7:3]: expected 0, got %0d", beat[7:3]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [WordW-1:0]     s_tdata   = '0;   // [15:0] header_word
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;          // [2:0] status, [7:3] zero
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [AddrW-1:0]     cfg_data  = '0;   // [31:0] local_address

  verdict_predictor     pred = new();
  logic [WordW-1:0]     word_stream[$];
  logic [AddrW-1:0]     addr_now  = '0;
  bit                   calm      = 1'b0;
  bit                   hold_req  = 1'b0;
  int                   hold_left = 0;
  int                   stall_cycles = 0;

  ipv4_header_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Builds a header with a correct checksum unless bad_csum is set.
  function automatic void queue_header(input logic [3:0] ver, input logic [3:0] ihl,
                                       input logic [7:0] ttl, input logic [AddrW-1:0] dst,
                                       input bit bad_csum);
    logic [WordW-1:0] w[10];
    logic [WordW-1:0] acc;
    w[0] = {ver, ihl, 8'($urandom)};
    w[1] = 16'($urandom);
    w[2] = 16'($urandom);
    w[3] = 16'($urandom);
    w[4] = {ttl, 8'($urandom)};
    w[5] = '0;
    w[6] = 16'($urandom);
    w[7] = 16'($urandom);
    w[8] = dst[31:16];
    w[9] = dst[15:0];
    acc = '0;
    for (int i = 0; i < 10; i++) acc = verdict_predictor::fold_add(acc, w[i]);
    w[5] = ~acc;
    if (bad_csum) begin
      w[5] = w[5] ^ 16'($urandom_range(16'hFFFF, 1));
      // a corrupted word that still sums to 16'hFFFF would pass
      if (verdict_predictor::fold_add(acc, w[5]) == CsumGood) w[5] = w[5] ^ 16'h0001;
    end
    for (int i = 0; i < 10; i++) word_stream.push_back(w[i]);
  endfunction

  function automatic void queue_raw(input bit rnd, input logic [WordW-1:0] fill);
    for (int i = 0; i < 10; i++) word_stream.push_back(rnd ? 16'($urandom) : fill);
  endfunction

  function automatic void queue_random_header();
    int               r;
    logic [3:0]       ver;
    logic [3:0]       ihl;
    logic [7:0]       ttl;
    logic [AddrW-1:0] dst;
    bit               bad;
    r   = $urandom_range(99);
    ver = IpVersion;
    ihl = 4'($urandom_range(15, 5));
    ttl = 8'($urandom_range(255, 1));
    dst = ($urandom_range(4) == 0) ? Broadcast : addr_now;
    bad = 1'b0;
    if (r < 15) begin
      queue_raw(1'b1, '0);
    end else begin
      if (r >= 60) begin
        if ($urandom_range(99) < 35)
          ver = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15, 5));
        if ($urandom_range(99) < 35) ihl = 4'($urandom_range(4));
        if ($urandom_range(99) < 35) ttl = 8'd0;
        if ($urandom_range(99) < 35) dst = $urandom;
        if ($urandom_range(99) < 35) bad = 1'b1;
      end
      queue_header(ver, ihl, ttl, dst, bad);
    end
  endfunction

  task automatic send_word(input logic [WordW-1:0] w);
    if (!calm && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_words(input int n);
    for (int i = 0; i < n; i++) begin
      if (word_stream.size() == 0) queue_random_header();
      send_word(word_stream.pop_front());
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pred.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_local(input logic [AddrW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    addr_now  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random back-pressure, quiet stretches and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Beat monitor and watchdog. Outputs are checked before new words are noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) pred.check_verdict(m_tdata);
      if (cfg_valid && cfg_ready) pred.local_addr = cfg_data;
      if (s_tvalid && s_tready) pred.take_word(s_tdata);
      if ((m_tvalid && m_tready) || (cfg_valid && cfg_ready) || (s_tvalid && s_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_local(32'h0000_0000);
    queue_header(IpVersion, 4'd5, 8'd255, addr_now, 1'b0);
    queue_header(IpVersion, 4'd15, 8'd1, Broadcast, 1'b0);
    queue_header(4'd0, 4'd5, 8'd64, addr_now, 1'b0);
    queue_header(4'd15, 4'd0, 8'd64, addr_now, 1'b1);
    queue_header(IpVersion, 4'd4, 8'd64, addr_now, 1'b0);
    queue_header(IpVersion, 4'd0, 8'd0, 32'h1234_5678, 1'b1);
    queue_header(IpVersion, 4'd5, 8'd0, addr_now, 1'b0);
    queue_header(IpVersion, 4'd6, 8'd32, 32'hC0A8_0001, 1'b0);
    queue_header(IpVersion, 4'd5, 8'd32, addr_now, 1'b1);
    queue_raw(1'b0, 16'h0000);
    queue_raw(1'b0, 16'hFFFF);
    run_words(word_stream.size());
    drain();

    write_local(32'hFFFF_FFFF);
    queue_header(IpVersion, 4'd5, 8'd128, 32'hFFFF_FFFF, 1'b0);
    queue_header(IpVersion, 4'd5, 8'd128, 32'h0000_0000, 1'b0);
    queue_header(IpVersion, 4'd5, 8'd128, 32'hFFFF_FFFE, 1'b1);
    run_words(word_stream.size());
    drain();

    // Phase lengths need not be whole headers, so some writes may land mid-header.
    for (int p = 0; p < 10; p++) begin
      case (p)
        4:       write_local(32'hFFFF_FFFF);
        8:       write_local(32'h0000_0000);
        default: write_local($urandom);
      endcase
      calm = (p == 2);
      n = $urandom_range(120, 100);
      if (p == 5) hold_req = 1'b1;
      if (p == 7) begin
        run_words(n / 2);
        drain();
        run_words(n - n / 2);
      end else begin
        run_words(n);
      end
      drain();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (pred.errors == 0 && pred.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
